// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the ring buffer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define FMRB_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FMRB_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define FMRB_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fmrb_pkg.sv =====
// shared types and codes of the framed message ring buffer
package fmrb_pkg;

  localparam int CAPACITY_DEF = 4096;

  // request codes
  localparam logic [2:0] REQ_OPEN_WR = 3'd0;
  localparam logic [2:0] REQ_WR_BYTE = 3'd1;
  localparam logic [2:0] REQ_OPEN_RD = 3'd2;
  localparam logic [2:0] REQ_RD_BYTE = 3'd3;
  localparam logic [2:0] REQ_CLEAR   = 3'd4;
  localparam logic [2:0] REQ_TICK    = 3'd5;

  // status codes
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_EMPTY   = 3'd1;
  localparam logic [2:0] STAT_NOSPACE = 3'd2;
  localparam logic [2:0] STAT_WBLOCK  = 3'd3;
  localparam logic [2:0] STAT_TOOBIG  = 3'd4;
  localparam logic [2:0] STAT_LENERR  = 3'd5;
  localparam logic [2:0] STAT_BADSEQ  = 3'd6;

  // buffer modes and overflow policies
  localparam logic [1:0] MODE_RAW  = 2'd0;
  localparam logic [1:0] MODE_LEN  = 2'd1;
  localparam logic [1:0] MODE_TIME = 2'd2;
  localparam logic [1:0] POL_REJECT = 2'd0;
  localparam logic [1:0] POL_EVICT  = 2'd1;
  localparam logic [1:0] POL_BLOCK  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE    = 2'd0;
  localparam logic [1:0] CFG_POLICY  = 2'd1;
  localparam logic [1:0] CFG_MAX_AGE = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RBYTE, S_EXPIRE, S_EXP_CHK, S_DROP, S_DROP_FIN,
    S_OPEN, S_PUT, S_COMMIT, S_RD_OPEN, S_RD_CHK, S_PEEK, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  policy;
    logic [15:0] max_age;
  } cfg_t;

  typedef struct packed {
    logic        last;
    logic [12:0] message_count;
    logic [12:0] fill_level;
    logic [12:0] length_out;
    logic [7:0]  byte_out;
    logic [2:0]  status;
  } res_t;

endpackage

// ===== hw/rtl/fmrb_ram.sv =====
// byte ring memory, one write and one registered read port
module fmrb_ram #(
  parameter int CAPACITY = fmrb_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(CAPACITY)-1:0] waddr,
  input  logic [7:0]                  wdata,
  input  logic [$clog2(CAPACITY)-1:0] raddr,
  output logic [7:0]                  rdata
);
  import fmrb_pkg::*;

  logic [7:0] mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fmrb_ctrl.sv =====
// request sequencer: walks headers one byte per cycle through the ring port
`include "assert_macros.svh"
module fmrb_ctrl #(
  parameter int CAPACITY = fmrb_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [2:0]                  req,
  input  logic [12:0]                 len,
  input  logic [7:0]                  dat,
  input  fmrb_pkg::cfg_t              cfg,
  output logic                        idle,
  output logic                        res_valid,
  output fmrb_pkg::res_t              res,
  output logic                        mem_we,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr,
  output logic [7:0]                  mem_wdata,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr,
  input  logic [7:0]                  mem_rdata
);
  import fmrb_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = ((CW > 13) ? CW : 13) + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  state_t state, state_next, pk_ret, drop_ret;
  kind_t kind;
  logic [2:0] req_q, status_q;
  logic [12:0] len_q, lout;
  logic [7:0] dat_q, bout;
  logic [1:0] mode_q, put_cnt;
  logic [3:0] hdr_q, drop_hdr;
  logic [AW-1:0] rp, wp, pk_ptr;
  logic [CW-1:0] free, msgs, left;
  logic [31:0] secs, word, put_word;
  logic [2:0] pk_cnt;
  logic put_more, last_q;

  logic [CW-1:0] fill, raw_n, evict_n;
  logic [LW-1:0] fill_l, free_l, need;
  logic [32:0] skip;
  logic [31:0] age;
  logic skip_bad, rd_bad, byte_bad, exp_on, clr_ring;
  state_t open_tgt;

  // pointer advance modulo the ring size
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] p, input logic [CW-1:0] n);
    logic [CW:0] s;
    s = (CW+1)'(p) + (CW+1)'(n);
    if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
    return s[AW-1:0];
  endfunction

  // message count saturating at zero
  function automatic logic [CW-1:0] cdown(input logic [CW-1:0] c, input logic [CW-1:0] n);
    return (c > n) ? c - n : '0;
  endfunction

  // message count saturating at capacity
  function automatic logic [CW-1:0] cup(input logic [CW-1:0] c, input logic [LW-1:0] n);
    logic [LW-1:0] s;
    s = LW'(c) + n;
    return (s > CAP_L) ? CAP_C : CW'(s);
  endfunction

  // count reduced to the 13-bit result field
  function automatic logic [12:0] msgs_l13(input logic [CW-1:0] c);
    logic [LW-1:0] w;
    w = LW'(c);
    return w[12:0];
  endfunction

  // shared compare terms
  assign fill     = CAP_C - free;
  assign fill_l   = LW'(fill);
  assign free_l   = LW'(free);
  assign need     = LW'(len_q) + LW'(hdr_q);
  assign raw_n    = (fill_l > LW'(len_q)) ? CW'(len_q) : fill;
  assign evict_n  = CW'(need - free_l);
  assign skip     = 33'(drop_hdr) + 33'(word);
  assign skip_bad = skip > 33'(fill);
  assign age      = secs - word;
  assign rd_bad   = (word > 32'(len_q)) || (word > 32'(fill - CW'(hdr_q)));
  assign byte_bad = (left == '0) ||
                    (kind != ((req_q == REQ_WR_BYTE) ? KIND_WRITE : KIND_READ));
  assign exp_on   = (mode_q == MODE_TIME) && (cfg.max_age != '0) && (fill != '0);
  assign open_tgt = (req_q == REQ_OPEN_WR) ? S_OPEN : S_RD_OPEN;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (take) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (req_q == REQ_OPEN_WR || req_q == REQ_OPEN_RD) begin
          if (kind != KIND_NONE) state_next = S_DONE;
          else if (exp_on) state_next = S_EXPIRE;
          else state_next = open_tgt;
        end else if (req_q == REQ_RD_BYTE && !byte_bad) begin
          state_next = S_RBYTE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RBYTE:    state_next = S_DONE;
      S_EXPIRE:   state_next = (fill_l < LW'(8)) ? open_tgt : S_PEEK;
      S_EXP_CHK:  state_next = (age <= 32'(cfg.max_age)) ? open_tgt : S_DROP;
      S_DROP:     state_next = (fill_l < LW'(drop_hdr)) ? drop_ret : S_PEEK;
      S_DROP_FIN: state_next = drop_ret;
      S_OPEN: begin
        if (need > CAP_L) state_next = S_DONE;
        else if (need <= free_l) state_next = (mode_q == MODE_RAW) ? S_COMMIT : S_PUT;
        else if (cfg.policy == POL_EVICT) state_next = (mode_q == MODE_RAW) ? S_OPEN : S_DROP;
        else state_next = S_DONE;
      end
      S_PUT:      if (put_cnt == 2'd3 && !put_more) state_next = S_COMMIT;
      S_COMMIT:   state_next = S_DONE;
      S_RD_OPEN: begin
        if (fill == '0 || mode_q == MODE_RAW || fill_l < LW'(hdr_q)) state_next = S_DONE;
        else state_next = S_PEEK;
      end
      S_RD_CHK:   state_next = S_DONE;
      S_PEEK:     if (pk_cnt == 3'd4) state_next = pk_ret;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // ring clearing, memory port control and result outputs
  always_comb begin
    clr_ring = 1'b0;
    unique case (state)
      S_DISPATCH: clr_ring = (req_q == REQ_CLEAR);
      S_EXPIRE:   clr_ring = (fill != '0) && (fill_l < LW'(8));
      S_DROP:     clr_ring = fill_l < LW'(drop_hdr);
      S_DROP_FIN: clr_ring = skip_bad;
      S_OPEN:     clr_ring = (need > CAP_L) && (cfg.policy == POL_EVICT);
      S_RD_OPEN:  clr_ring = (fill != '0) && (mode_q != MODE_RAW) && (fill_l < LW'(hdr_q));
      S_RD_CHK:   clr_ring = rd_bad;
      default:    clr_ring = 1'b0;
    endcase
    mem_we    = (state == S_PUT) ||
                (state == S_DISPATCH && req_q == REQ_WR_BYTE && !byte_bad);
    mem_waddr = wp;
    mem_wdata = (state == S_PUT) ? put_word[7:0] : dat_q;
    mem_raddr = (state == S_PEEK) ? pk_ptr : rp;
    idle      = (state == S_IDLE);
    res_valid = (state == S_DONE);
    res.status        = status_q;
    res.byte_out      = bout;
    res.length_out    = lout;
    res.fill_level    = fill_l[12:0];
    res.message_count = msgs_l13(msgs);
    res.last          = last_q;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rp   <= '0;
      wp   <= '0;
      free <= CAP_C;
      msgs <= '0;
      secs <= '0;
      left <= '0;
      kind <= KIND_NONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            req_q    <= req;
            len_q    <= len;
            dat_q    <= dat;
            mode_q   <= (cfg.mode == MODE_LEN || cfg.mode == MODE_TIME) ? cfg.mode : MODE_RAW;
            hdr_q    <= (cfg.mode == MODE_LEN) ? 4'd4 : ((cfg.mode == MODE_TIME) ? 4'd8 : 4'd0);
            status_q <= STAT_OK;
            bout     <= '0;
            lout     <= '0;
            last_q   <= 1'b0;
          end
        end
        S_DISPATCH: begin
          unique case (req_q)
            REQ_OPEN_WR, REQ_OPEN_RD: begin
              if (kind != KIND_NONE) status_q <= STAT_BADSEQ;
            end
            REQ_WR_BYTE: begin
              if (byte_bad) begin
                status_q <= STAT_BADSEQ;
              end else begin
                wp   <= wrap(wp, CW'(1));
                left <= left - CW'(1);
                if (left == CW'(1)) begin
                  kind   <= KIND_NONE;
                  last_q <= 1'b1;
                end
              end
            end
            REQ_RD_BYTE: if (byte_bad) status_q <= STAT_BADSEQ;
            REQ_CLEAR:   status_q <= STAT_OK;
            REQ_TICK:    secs <= secs + 32'd1;
            default:     status_q <= STAT_BADSEQ;
          endcase
        end
        S_RBYTE: begin
          bout <= mem_rdata;
          rp   <= wrap(rp, CW'(1));
          left <= left - CW'(1);
          if (left == CW'(1)) begin
            kind   <= KIND_NONE;
            last_q <= 1'b1;
          end
        end
        S_EXPIRE: begin
          if (fill_l >= LW'(8)) begin
            pk_ptr <= rp;
            pk_cnt <= '0;
            pk_ret <= S_EXP_CHK;
          end
        end
        S_EXP_CHK: begin
          drop_hdr <= 4'd8;
          drop_ret <= S_EXPIRE;
        end
        S_DROP: begin
          pk_ptr <= wrap(rp, CW'(drop_hdr - 4'd4));
          pk_cnt <= '0;
          pk_ret <= S_DROP_FIN;
        end
        S_DROP_FIN: begin
          if (!skip_bad) begin
            rp   <= wrap(rp, CW'(skip));
            free <= free + CW'(skip);
            msgs <= cdown(msgs, CW'(1));
          end
        end
        S_OPEN: begin
          if (need > CAP_L) begin
            status_q <= (cfg.policy == POL_BLOCK) ? STAT_TOOBIG : STAT_NOSPACE;
          end else if (need <= free_l) begin
            put_cnt  <= '0;
            put_more <= (mode_q == MODE_TIME);
            put_word <= (mode_q == MODE_TIME) ? secs : 32'(len_q);
          end else if (cfg.policy == POL_EVICT) begin
            if (mode_q == MODE_RAW) begin
              rp   <= wrap(rp, evict_n);
              free <= free + evict_n;
              msgs <= cdown(msgs, evict_n);
            end else begin
              drop_hdr <= hdr_q;
              drop_ret <= S_OPEN;
            end
          end else begin
            status_q <= (cfg.policy == POL_BLOCK) ? STAT_WBLOCK : STAT_NOSPACE;
          end
        end
        S_PUT: begin
          wp      <= wrap(wp, CW'(1));
          put_cnt <= put_cnt + 2'd1;
          if (put_cnt == 2'd3 && put_more) begin
            put_word <= 32'(len_q);
            put_more <= 1'b0;
          end else begin
            put_word <= put_word >> 8;
          end
        end
        S_COMMIT: begin
          msgs <= cup(msgs, (mode_q == MODE_RAW) ? LW'(len_q) : LW'(1));
          free <= free - CW'(need);
          left <= CW'(len_q);
          kind <= (len_q != '0) ? KIND_WRITE : KIND_NONE;
          lout <= len_q;
        end
        S_RD_OPEN: begin
          if (fill == '0) begin
            status_q <= STAT_EMPTY;
          end else if (mode_q == MODE_RAW) begin
            free <= free + raw_n;
            msgs <= cdown(msgs, raw_n);
            left <= raw_n;
            kind <= (raw_n != '0) ? KIND_READ : KIND_NONE;
            lout <= msgs_l13(raw_n);
          end else if (fill_l < LW'(hdr_q)) begin
            status_q <= STAT_LENERR;
          end else begin
            pk_ptr <= wrap(rp, CW'(hdr_q - 4'd4));
            pk_cnt <= '0;
            pk_ret <= S_RD_CHK;
          end
        end
        S_RD_CHK: begin
          lout <= word[12:0];
          if (rd_bad) begin
            status_q <= STAT_LENERR;
          end else begin
            rp   <= wrap(rp, CW'(hdr_q));
            free <= free + CW'(hdr_q) + CW'(word);
            msgs <= cdown(msgs, CW'(1));
            left <= CW'(word);
            kind <= (word != '0) ? KIND_READ : KIND_NONE;
          end
        end
        S_PEEK: begin
          // one header byte per cycle, little endian into the word
          if (pk_cnt != '0) word <= {mem_rdata, word[31:8]};
          pk_ptr <= wrap(pk_ptr, CW'(1));
          pk_cnt <= pk_cnt + 3'd1;
        end
        S_DONE: begin
          status_q <= status_q;
        end
        default: begin
          status_q <= status_q;
        end
      endcase
      // empty the ring
      if (clr_ring) begin
        rp   <= '0;
        wp   <= '0;
        free <= CAP_C;
        msgs <= '0;
        left <= '0;
        kind <= KIND_NONE;
      end
    end
  end

  `FMRB_CHECK(a_free_cap, free <= CAP_C, "free bytes above capacity")
  `FMRB_IMPLY(a_kind_left, kind != KIND_NONE, left != '0, "open transfer with nothing left")
  `FMRB_CHECK(a_take_idle, !take || state == S_IDLE, "request taken while busy")
  `FMRB_NEXT(a_done_idle, state == S_DONE, state == S_IDLE && !res_valid, "result held")

endmodule

// ===== hw/rtl/framed_message_ring_buffer_top.sv =====
// Framed message ring buffer top: config registers, sequencer, ring, result beat.
// Byte writes pass dispatch and done; byte reads add a ring read state. Opens take more
// because each header word is read one byte per cycle through the single ring read port,
// repeated per evicted or expired message; header writes go byte by byte to the write port.
// One request at a time: accepted only when idle and the result beat is free or draining.
// Synchronous reset empties the ring, clears config and time.
module framed_message_ring_buffer_top #(
  parameter int CAPACITY = fmrb_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // req_type[2:0], msg_length[15:3], data_byte[23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // status, byte_out, length_out, fill_level, message_count
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import fmrb_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  cfg_t cfg;
  res_t res;
  logic take, idle, res_valid, mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata, mem_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:    cfg.mode    <= cfg_data[1:0];
        CFG_POLICY:  cfg.policy  <= cfg_data[1:0];
        CFG_MAX_AGE: cfg.max_age <= cfg_data;
        default:     cfg <= cfg;
      endcase
    end
  end

  // accept only while the sequencer is idle and the output stage is free or draining
  assign s_tready = idle && (!m_tvalid || m_tready);
  assign take     = s_tvalid && s_tready;

  fmrb_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk, .rst, .take,
    .req(s_tdata[2:0]), .len(s_tdata[15:3]), .dat(s_tdata[23:16]),
    .cfg, .idle, .res_valid, .res,
    .mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata
  );

  fmrb_ram #(.CAPACITY(CAPACITY)) u_ram (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {6'd0, res.message_count, res.fill_level, res.length_out,
                  res.byte_out, res.status};
      m_tlast <= res.last;
    end
  end

endmodule

// ===== tb/tb_framed_message_ring_buffer_top.sv =====
// testbench for the framed message ring buffer: directed table, then randomized streams
`timescale 1ns / 1ps

module tb_framed_message_ring_buffer_top;
  import fmrb_pkg::*;

  localparam int RING_BYTES = 4096;
  localparam int STALL_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  framed_message_ring_buffer_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the ring and its bookkeeping
  logic [7:0]  ring_shadow [RING_BYTES];
  int unsigned rd_ptr, wr_ptr, free_cnt, msg_cnt, seconds, xfer_left;
  kind_t       xfer_kind;
  int unsigned mode_reg, policy_reg, age_reg;

  res_t pending_results[$];
  bit   failed;
  int   tx_idle_pct, rx_stall_pct, rx_hold;

  function automatic int unsigned fill_bytes();
    return RING_BYTES - free_cnt;
  endfunction

  function automatic int unsigned wrap(int unsigned p, int unsigned n);
    return int'((longint'(p) + longint'(n)) % RING_BYTES);
  endfunction

  function automatic int unsigned peek_word(int unsigned p);
    int unsigned v;
    v = 0;
    for (int i = 0; i < 4; i++) v |= int'(ring_shadow[wrap(p, i)]) << (8 * i);
    return v;
  endfunction

  task automatic put_word(int unsigned v);
    for (int i = 0; i < 4; i++) begin
      ring_shadow[wr_ptr] = v[8*i +: 8];
      wr_ptr = wrap(wr_ptr, 1);
    end
  endtask

  task automatic count_down(int unsigned n);
    msg_cnt = (msg_cnt > n) ? msg_cnt - n : 0;
  endtask

  task automatic empty_ring();
    rd_ptr = 0;
    wr_ptr = 0;
    free_cnt = RING_BYTES;
    msg_cnt = 0;
    xfer_left = 0;
    xfer_kind = KIND_NONE;
  endtask

  // drop oldest framed message, clearing the ring on bad framing
  task automatic drop_oldest(int unsigned hdr);
    longint skip;
    if (fill_bytes() < hdr) begin
      empty_ring();
      return;
    end
    skip = longint'(hdr) + longint'(peek_word(wrap(rd_ptr, hdr - 4)));
    if (skip > fill_bytes()) begin
      empty_ring();
      return;
    end
    rd_ptr = wrap(rd_ptr, int'(skip));
    free_cnt += int'(skip);
    count_down(1);
  endtask

  task automatic expire_aged();
    while (fill_bytes() > 0) begin
      if (fill_bytes() < 8) begin
        empty_ring();
        return;
      end
      if (seconds - peek_word(rd_ptr) <= age_reg) return;
      drop_oldest(8);
    end
  endtask

  // expected result of one accepted request beat, updating the shadow state
  task automatic ring_predict(input logic [2:0] req, input int unsigned len,
                              input logic [7:0] dat, output res_t r);
    int unsigned m, hdr, st, bo, lo, lst, need, n, found;
    m = (mode_reg == MODE_LEN || mode_reg == MODE_TIME) ? mode_reg : MODE_RAW;
    hdr = (m == MODE_RAW) ? 0 : ((m == MODE_LEN) ? 4 : 8);
    st = STAT_OK; bo = 0; lo = 0; lst = 0;
    if (req == REQ_OPEN_WR || req == REQ_OPEN_RD) begin
      if (xfer_kind != KIND_NONE) begin
        st = STAT_BADSEQ;
      end else begin
        if (m == MODE_TIME && age_reg != 0 && fill_bytes() > 0) expire_aged();
        if (req == REQ_OPEN_WR) begin
          need = len + hdr;
          if (need > RING_BYTES) begin
            if (policy_reg == POL_EVICT) empty_ring();
            st = (policy_reg == POL_BLOCK) ? STAT_TOOBIG : STAT_NOSPACE;
          end else begin
            while (need > free_cnt && st == STAT_OK) begin
              if (policy_reg == POL_EVICT) begin
                if (m == MODE_RAW) begin
                  n = need - free_cnt;
                  rd_ptr = wrap(rd_ptr, n);
                  free_cnt += n;
                  count_down(n);
                end else begin
                  drop_oldest(hdr);
                end
              end else begin
                st = (policy_reg == POL_BLOCK) ? STAT_WBLOCK : STAT_NOSPACE;
              end
            end
            if (st == STAT_OK) begin
              if (m == MODE_TIME) put_word(seconds);
              if (m != MODE_RAW) begin
                put_word(len);
                msg_cnt = (msg_cnt + 1 > RING_BYTES) ? RING_BYTES : msg_cnt + 1;
              end else begin
                msg_cnt = (msg_cnt + len > RING_BYTES) ? RING_BYTES : msg_cnt + len;
              end
              free_cnt -= need;
              xfer_left = len;
              xfer_kind = len ? KIND_WRITE : KIND_NONE;
              lo = len;
            end
          end
        end else if (fill_bytes() == 0) begin
          st = STAT_EMPTY;
        end else if (m == MODE_RAW) begin
          n = (len < fill_bytes()) ? len : fill_bytes();
          free_cnt += n;
          count_down(n);
          xfer_left = n;
          xfer_kind = n ? KIND_READ : KIND_NONE;
          lo = n;
        end else if (fill_bytes() < hdr) begin
          empty_ring();
          st = STAT_LENERR;
        end else begin
          found = peek_word(wrap(rd_ptr, hdr - 4));
          rd_ptr = wrap(rd_ptr, hdr);
          free_cnt += hdr;
          lo = found;
          if (found > len || found > fill_bytes()) begin
            empty_ring();
            st = STAT_LENERR;
          end else begin
            free_cnt += found;
            count_down(1);
            xfer_left = found;
            xfer_kind = found ? KIND_READ : KIND_NONE;
          end
        end
      end
    end else if (req == REQ_WR_BYTE || req == REQ_RD_BYTE) begin
      if (xfer_kind != ((req == REQ_WR_BYTE) ? KIND_WRITE : KIND_READ) || xfer_left == 0) begin
        st = STAT_BADSEQ;
      end else begin
        if (req == REQ_WR_BYTE) begin
          ring_shadow[wr_ptr] = dat;
          wr_ptr = wrap(wr_ptr, 1);
        end else begin
          bo = ring_shadow[rd_ptr];
          rd_ptr = wrap(rd_ptr, 1);
        end
        xfer_left--;
        if (xfer_left == 0) begin
          xfer_kind = KIND_NONE;
          lst = 1;
        end
      end
    end else if (req == REQ_CLEAR) begin
      empty_ring();
    end else if (req == REQ_TICK) begin
      seconds += 1;
    end else begin
      st = STAT_BADSEQ;
    end
    r.status = st[2:0];
    r.byte_out = bo[7:0];
    r.length_out = lo[12:0];
    r.fill_level = 13'(fill_bytes());
    r.message_count = 13'(msg_cnt);
    r.last = lst[0];
  endtask

  // offer one request beat; predict at the accepting edge
  task automatic send_req(logic [2:0] req, logic [12:0] len, logic [7:0] dat,
                          bit typed = 0, res_t typed_res = '0);
    res_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {dat, len, req};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    ring_predict(req, 32'(len), dat, r);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:    mode_reg = val[1:0];
      CFG_POLICY:  policy_reg = val[1:0];
      CFG_MAX_AGE: age_reg = val;
      default: ;
    endcase
  endtask

  // result checker and watchdog
  int stall_cycles;
  always @(posedge clk) begin
    res_t e;
    logic [2:0] st;
    logic [7:0] bo;
    logic [12:0] lo, fl, mc;
    if (!rst) begin
      st = m_tdata[2:0];   bo = m_tdata[10:3];  lo = m_tdata[23:11];
      fl = m_tdata[36:24]; mc = m_tdata[49:37];
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
          failed = 1;
        end else begin
          e = pending_results.pop_front();
          if (st !== e.status || bo !== e.byte_out || lo !== e.length_out ||
              fl !== e.fill_level || mc !== e.message_count || m_tlast !== e.last) begin
            $display("%0t: mismatch expected st=%0d byte=%0d len=%0d fill=%0d cnt=%0d last=%0d",
                     $time, e.status, e.byte_out, e.length_out, e.fill_level,
                     e.message_count, e.last);
            $display("%0t:          actual   st=%0d byte=%0d len=%0d fill=%0d cnt=%0d last=%0d",
                     $time, st, bo, lo, fl, mc, m_tlast);
            failed = 1;
          end
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver readiness, with a long hold-off counted down here
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  typedef struct {
    logic [2:0]  req;
    logic [12:0] len;
    logic [7:0]  dat;
    res_t        want;
  } dir_row_t;

  function automatic res_t mk(logic [2:0] st, logic [7:0] b, logic [12:0] l,
                              logic [12:0] f, logic [12:0] c, logic lst);
    res_t r;
    r.status = st; r.byte_out = b; r.length_out = l;
    r.fill_level = f; r.message_count = c; r.last = lst;
    return r;
  endfunction

  // pick and send one random request, mostly following the open transfer
  task automatic random_req(int big_pct);
    int unsigned pick, len;
    pick = $urandom_range(99);
    if (xfer_kind == KIND_WRITE && pick < 93) begin
      send_req(REQ_WR_BYTE, 13'($urandom_range(8191)), 8'($urandom_range(255)));
    end else if (xfer_kind == KIND_READ && pick < 93) begin
      send_req(REQ_RD_BYTE, 13'($urandom_range(8191)), 8'($urandom_range(255)));
    end else begin
      pick = $urandom_range(99);
      if (pick < 38) begin
        len = $urandom_range(24);
        if ($urandom_range(99) < big_pct) len = $urandom_range(200, 1500);
        else if ($urandom_range(99) < 3) len = $urandom_range(8191);
        send_req(REQ_OPEN_WR, 13'(len), 8'($urandom_range(255)));
      end else if (pick < 72) begin
        len = ($urandom_range(99) < 70) ? 4096 : $urandom_range(8191);
        if ($urandom_range(99) < 15) len = $urandom_range(40);
        send_req(REQ_OPEN_RD, 13'(len), 8'($urandom_range(255)));
      end else if (pick < 84) begin
        send_req(REQ_TICK, 13'($urandom_range(8191)), 8'($urandom_range(255)));
      end else if (pick < 87) begin
        send_req(REQ_CLEAR, 13'($urandom_range(8191)), 8'($urandom_range(255)));
      end else if (pick < 91) begin
        send_req(3'($urandom_range(6, 7)), 13'($urandom_range(8191)),
                 8'($urandom_range(255)));
      end else begin
        send_req($urandom_range(0, 1) ? REQ_WR_BYTE : REQ_RD_BYTE,
                 13'($urandom_range(8191)), 8'($urandom_range(255)));
      end
    end
  endtask

  dir_row_t dir_rows[$];
  int unsigned phase_cfg[10][3] = '{
    '{0, 0, 0}, '{1, 0, 0}, '{1, 1, 0}, '{1, 2, 0}, '{2, 1, 3},
    '{2, 2, 65535}, '{2, 0, 1}, '{0, 1, 0}, '{3, 3, 0}, '{0, 2, 2}
  };

  initial begin
    int idle_mode;
    for (int i = 0; i < RING_BYTES; i++) ring_shadow[i] = 8'h00;
    empty_ring();
    seconds = 0; mode_reg = 0; policy_reg = 0; age_reg = 0;
    failed = 0; tx_idle_pct = 0; rx_stall_pct = 0; rx_hold = 0; stall_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table in reset configuration
    dir_rows = '{
      '{REQ_OPEN_RD, 13'd5,    8'h00, mk(STAT_EMPTY,  0, 0, 0, 0, 0)},
      '{REQ_RD_BYTE, 13'd0,    8'h00, mk(STAT_BADSEQ, 0, 0, 0, 0, 0)},
      '{REQ_WR_BYTE, 13'd0,    8'h12, mk(STAT_BADSEQ, 0, 0, 0, 0, 0)},
      '{3'd6,        13'h1fff, 8'hff, mk(STAT_BADSEQ, 0, 0, 0, 0, 0)},
      '{3'd7,        13'd0,    8'h00, mk(STAT_BADSEQ, 0, 0, 0, 0, 0)},
      '{REQ_OPEN_WR, 13'h1fff, 8'h00, mk(STAT_NOSPACE, 0, 0, 0, 0, 0)},
      '{REQ_OPEN_WR, 13'd0,    8'h00, mk(STAT_OK, 0, 0, 0, 0, 0)},
      '{REQ_OPEN_WR, 13'd2,    8'h00, mk(STAT_OK, 0, 2, 2, 2, 0)},
      '{REQ_WR_BYTE, 13'd0,    8'hff, mk(STAT_OK, 0, 0, 2, 2, 0)},
      '{REQ_WR_BYTE, 13'd0,    8'h00, mk(STAT_OK, 0, 0, 2, 2, 1)},
      '{REQ_OPEN_WR, 13'd1,    8'h00, mk(STAT_OK, 0, 1, 3, 3, 0)},
      '{REQ_WR_BYTE, 13'd0,    8'ha5, mk(STAT_OK, 0, 0, 3, 3, 1)},
      '{REQ_OPEN_RD, 13'h1fff, 8'h00, mk(STAT_OK, 0, 3, 0, 0, 0)},
      '{REQ_RD_BYTE, 13'd0,    8'h00, mk(STAT_OK, 8'hff, 0, 0, 0, 0)},
      '{REQ_RD_BYTE, 13'd0,    8'h00, mk(STAT_OK, 8'h00, 0, 0, 0, 0)},
      '{REQ_RD_BYTE, 13'd0,    8'h00, mk(STAT_OK, 8'ha5, 0, 0, 0, 1)},
      '{REQ_TICK,    13'd0,    8'h00, mk(STAT_OK, 0, 0, 0, 0, 0)},
      '{REQ_OPEN_WR, 13'd4096, 8'h00, mk(STAT_OK, 0, 4096, 4096, 4096, 0)},
      '{REQ_OPEN_RD, 13'd4096, 8'h00, mk(STAT_BADSEQ, 0, 0, 4096, 4096, 0)},
      '{REQ_CLEAR,   13'd0,    8'h00, mk(STAT_OK, 0, 0, 0, 0, 0)}
    };
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].len, dir_rows[i].dat,
                                   1, dir_rows[i].want);

    // random phases over the configuration corners
    for (int ph = 0; ph < 10; ph++) begin
      cfg_write(CFG_MODE, 16'(phase_cfg[ph][0]));
      cfg_write(CFG_POLICY, 16'(phase_cfg[ph][1]));
      cfg_write(CFG_MAX_AGE, 16'(phase_cfg[ph][2]));
      idle_mode = ph % 4;
      tx_idle_pct = (idle_mode == 1) ? 54 : ((idle_mode == 3) ? 32 : 0);
      rx_stall_pct = (idle_mode == 2) ? 54 : ((idle_mode == 3) ? 32 : 0);
      if (ph == 2) rx_hold = 400;
      for (int k = 0; k < 150; k++) random_req((phase_cfg[ph][1] != 0) ? 3 : 1);
    end

    drain();
    repeat (60) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/fmrb_pkg.sv
hw/rtl/fmrb_ram.sv
hw/rtl/fmrb_ctrl.sv
hw/rtl/framed_message_ring_buffer_top.sv
tb/tb_framed_message_ring_buffer_top.sv
